### hdl/tilt_compensated_compass_heading_core_assert.svh
// Assertion macros for the compass heading core
`ifndef TILT_COMPENSATED_COMPASS_HEADING_CORE_ASSERT_SVH
`define TILT_COMPENSATED_COMPASS_HEADING_CORE_ASSERT_SVH

// consequent must hold whenever antecedent holds
`define TCH_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// consequent must hold in the cycle after antecedent
`define TCH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### hdl/tcch_pkg.sv
`timescale 1ns / 1ps
package tcch_pkg;
    localparam int MAX_STAGES = 32;
    localparam int ANG_W = 40;
    localparam int TRIG_W = 34;
    localparam int HV_W = 50;
    localparam int MAG_W = 13;
    localparam int IN_ANG_W = 16;
    localparam int HEAD_W = 16;
    localparam logic signed [ANG_W-1:0] TURN_IN = 40'sd46080;
    localparam logic signed [ANG_W-1:0] HALF_IN = 40'sd23040;
    localparam logic signed [ANG_W-1:0] DEG90 = 40'sd754974720;
    localparam logic signed [ANG_W-1:0] DEG180 = 40'sd1509949440;
    localparam logic signed [ANG_W-1:0] DEG360 = 40'sd3019898880;
    localparam logic signed [TRIG_W-1:0] GAIN_INV = 34'sd652032854;

    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            5'd0: r = 40'sd377487360;
            5'd1: r = 40'sd222843801;
            5'd2: r = 40'sd117744544;
            5'd3: r = 40'sd59768969;
            5'd4: r = 40'sd30000467;
            5'd5: r = 40'sd15014858;
            5'd6: r = 40'sd7509261;
            5'd7: r = 40'sd3754860;
            5'd8: r = 40'sd1877459;
            5'd9: r = 40'sd938733;
            5'd10: r = 40'sd469367;
            5'd11: r = 40'sd234683;
            5'd12: r = 40'sd117342;
            5'd13: r = 40'sd58671;
            5'd14: r = 40'sd29335;
            5'd15: r = 40'sd14668;
            5'd16: r = 40'sd7334;
            5'd17: r = 40'sd3667;
            5'd18: r = 40'sd1833;
            5'd19: r = 40'sd917;
            5'd20: r = 40'sd458;
            5'd21: r = 40'sd229;
            5'd22: r = 40'sd115;
            5'd23: r = 40'sd57;
            5'd24: r = 40'sd29;
            5'd25: r = 40'sd14;
            5'd26: r = 40'sd7;
            5'd27: r = 40'sd4;
            5'd28: r = 40'sd2;
            5'd29: r = 40'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

### hdl/tilt_compensated_compass_heading_core.sv
`timescale 1ns / 1ps
// Tilt-compensated compass heading: one word per cycle in, one heading word per cycle out while
// the output is not stalled. Words pass the unrolled CORDIC sine/cosine pipelines, then the
// three-stage tilt multiply, then the unrolled CORDIC arctangent pipeline. Heading is 0..46079 in
// 1/128 degree. The whole pipeline advances together when the output slot is free or being
// taken.
module tilt_compensated_compass_heading_core
    import tcch_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [MAG_W-1:0]    field_x,
    input  logic signed [MAG_W-1:0]    field_y,
    input  logic signed [MAG_W-1:0]    field_z,
    input  logic signed [IN_ANG_W-1:0] pitch_angle,
    input  logic signed [IN_ANG_W-1:0] roll_angle,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic        [HEAD_W-1:0]   heading_angle
);
    localparam int N = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    localparam int ROT_LAT = N + 1;
    localparam int LAT = 2 * N + 6;

    logic                     adv;
    logic [LAT-1:0]           vld_reg;
    logic signed [MAG_W-1:0]  fx_reg [0:ROT_LAT-1];
    logic signed [MAG_W-1:0]  fy_reg [0:ROT_LAT-1];
    logic signed [MAG_W-1:0]  fz_reg [0:ROT_LAT-1];
    logic signed [TRIG_W-1:0] sp, cp, sr, cr;
    logic signed [HV_W-1:0]   xh, yh;

    assign out_valid = vld_reg[LAT-1];
    assign adv = !out_valid || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx_reg[0] <= field_x;
            fy_reg[0] <= field_y;
            fz_reg[0] <= field_z;
        end
    end

    for (genvar i = 1; i < ROT_LAT; i++)
    begin : g_dly
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                fx_reg[i] <= fx_reg[i-1];
                fy_reg[i] <= fy_reg[i-1];
                fz_reg[i] <= fz_reg[i-1];
            end
        end
    end

    tcch_rot #(.STAGES(N)) u_pitch (
        .clk(clk), .adv(adv), .ang(pitch_angle),
        .sin_val(sp), .cos_val(cp)
    );

    tcch_rot #(.STAGES(N)) u_roll (
        .clk(clk), .adv(adv), .ang(roll_angle),
        .sin_val(sr), .cos_val(cr)
    );

    tcch_tilt u_tilt (
        .clk(clk), .adv(adv),
        .fx(fx_reg[ROT_LAT-1]), .fy(fy_reg[ROT_LAT-1]), .fz(fz_reg[ROT_LAT-1]),
        .sp(sp), .cp(cp), .sr(sr), .cr(cr), .xh(xh), .yh(yh)
    );

    tcch_vec #(.STAGES(N)) u_vec (
        .clk(clk), .adv(adv), .xh(xh), .yh(yh), .heading(heading_angle)
    );

`include "tilt_compensated_compass_heading_core_assert.svh"

    `TCH_ASSERT_IMPL(a_head_range, out_valid, heading_angle < 16'd46080)
    `TCH_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(heading_angle))
    `TCH_ASSERT_IMPL(a_ready, out_valid && !out_ready, !in_ready)
endmodule

### hdl/tcch_rot.sv
`timescale 1ns / 1ps
module tcch_rot
    import tcch_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic                       clk,
    input  logic                       adv,
    input  logic signed [IN_ANG_W-1:0] ang,
    output logic signed [TRIG_W-1:0]   sin_val,
    output logic signed [TRIG_W-1:0]   cos_val
);
    localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;

    logic signed [TRIG_W-1:0] x_reg [0:N];
    logic signed [TRIG_W-1:0] y_reg [0:N];
    logic signed [ANG_W-1:0]  z_reg [0:N];
    logic                     neg_reg [0:N];
    logic signed [ANG_W-1:0]  a_next;
    logic signed [ANG_W-1:0]  z_next;
    logic                     neg_next;

    always_comb
    begin
        a_next = ANG_W'(ang);
        if (a_next > HALF_IN)
            a_next = a_next - TURN_IN;
        else if (a_next < -HALF_IN)
            a_next = a_next + TURN_IN;
        z_next = a_next <<< 16;
        neg_next = 1'b0;
        if (z_next > DEG90)
        begin
            z_next = z_next - DEG180;
            neg_next = 1'b1;
        end
        else if (z_next < -DEG90)
        begin
            z_next = z_next + DEG180;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= GAIN_INV;
            y_reg[0] <= '0;
            z_reg[0] <= z_next;
            neg_reg[0] <= neg_next;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!z_reg[i][ANG_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_lut(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_lut(5'(i));
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign cos_val = neg_reg[N] ? -x_reg[N] : x_reg[N];
    assign sin_val = neg_reg[N] ? -y_reg[N] : y_reg[N];
endmodule

### hdl/tcch_tilt.sv
`timescale 1ns / 1ps
module tcch_tilt
    import tcch_pkg::*;
(
    input  logic                     clk,
    input  logic                     adv,
    input  logic signed [MAG_W-1:0]  fx,
    input  logic signed [MAG_W-1:0]  fy,
    input  logic signed [MAG_W-1:0]  fz,
    input  logic signed [TRIG_W-1:0] sp,
    input  logic signed [TRIG_W-1:0] cp,
    input  logic signed [TRIG_W-1:0] sr,
    input  logic signed [TRIG_W-1:0] cr,
    output logic signed [HV_W-1:0]   xh,
    output logic signed [HV_W-1:0]   yh
);
    logic signed [67:0]       srsp_reg, srcp_reg;
    logic signed [HV_W-1:0]   xcp_reg, zsp_reg, ycr_reg;
    logic signed [MAG_W-1:0]  fx_reg, fz_reg;
    logic signed [HV_W-1:0]   xh_d_reg, ycr_d_reg;
    logic signed [HV_W-1:0]   a_reg, b_reg, xh_reg, yh_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            srsp_reg <= 68'(sr) * 68'(sp);
            srcp_reg <= 68'(sr) * 68'(cp);
            xcp_reg <= HV_W'(fx) * HV_W'(cp);
            zsp_reg <= HV_W'(fz) * HV_W'(sp);
            ycr_reg <= HV_W'(fy) * HV_W'(cr);
            fx_reg <= fx;
            fz_reg <= fz;
            xh_d_reg <= xcp_reg + zsp_reg;
            ycr_d_reg <= ycr_reg;
            a_reg <= HV_W'(fx_reg) * HV_W'(TRIG_W'(srsp_reg >>> 30));
            b_reg <= HV_W'(fz_reg) * HV_W'(TRIG_W'(srcp_reg >>> 30));
            xh_reg <= xh_d_reg;
            yh_reg <= a_reg + ycr_d_reg - b_reg;
        end
    end

    assign xh = xh_reg;
    assign yh = yh_reg;
endmodule

### hdl/tcch_vec.sv
`timescale 1ns / 1ps
module tcch_vec
    import tcch_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic                      clk,
    input  logic                      adv,
    input  logic signed [HV_W-1:0]    xh,
    input  logic signed [HV_W-1:0]    yh,
    output logic        [HEAD_W-1:0]  heading
);
    localparam int N = (STAGES > MAX_STAGES) ? MAX_STAGES : STAGES;
    localparam int VW = HV_W + 2;

    logic signed [VW-1:0]    x_reg [0:N];
    logic signed [VW-1:0]    y_reg [0:N];
    logic signed [ANG_W-1:0] z_reg [0:N];
    logic                    zero_reg [0:N];
    logic [HEAD_W-1:0]       h_reg;
    logic signed [ANG_W-1:0] zf;
    logic signed [ANG_W-1:0] hr;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zero_reg[0] <= (xh == '0) && (yh == '0);
            if (xh[HV_W-1])
            begin
                x_reg[0] <= -VW'(xh);
                y_reg[0] <= -VW'(yh);
                z_reg[0] <= DEG180;
            end
            else
            begin
                x_reg[0] <= VW'(xh);
                y_reg[0] <= VW'(yh);
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!y_reg[i][VW-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_lut(5'(i));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_lut(5'(i));
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    always_comb
    begin
        zf = z_reg[N];
        if (zf[ANG_W-1])
            zf = zf + DEG360;
        hr = (zf + 40'sd32768) >>> 16;
        if (hr >= TURN_IN)
            hr = hr - TURN_IN;
        if (hr[ANG_W-1] || zero_reg[N])
            hr = '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            h_reg <= HEAD_W'(hr);
    end

    assign heading = h_reg;
endmodule

### dv/tb_tilt_compensated_compass_heading_core.sv
`timescale 1ns / 1ps
module tb_tilt_compensated_compass_heading_core;
    import tcch_pkg::*;

    localparam int STAGES = 16;
    localparam int LATENCY = STAGES * 2 + 6;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint TURN = 46080;
    localparam longint HALF = 23040;
    localparam longint SCALE = 65536;
    localparam longint Q90 = 64'sd11520 * 65536;
    localparam longint Q180 = 64'sd23040 * 65536;
    localparam longint Q360 = 64'sd46080 * 65536;
    localparam longint UNIT_GAIN = 652032854;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [MAG_W-1:0] field_x;
    logic signed [MAG_W-1:0] field_y;
    logic signed [MAG_W-1:0] field_z;
    logic signed [IN_ANG_W-1:0] pitch_angle;
    logic signed [IN_ANG_W-1:0] roll_angle;
    logic out_valid;
    logic out_ready;
    logic [HEAD_W-1:0] heading_angle;

    logic [HEAD_W-1:0] heading_queue[$];
    int fail_count;
    int words_in;
    int words_out;
    int idle_cycles;
    bit hold_off;
    bit stall_enable;

    tilt_compensated_compass_heading_core #(.CORDIC_STAGES(STAGES)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .field_x(field_x),
        .field_y(field_y),
        .field_z(field_z),
        .pitch_angle(pitch_angle),
        .roll_angle(roll_angle),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .heading_angle(heading_angle)
    );

    always #5 clk = ~clk;

    function automatic longint atan_step(int i);
        longint steps[30] = '{377487360, 222843801, 117744544, 59768969, 30000467,
            15014858, 7509261, 3754860, 1877459, 938733, 469367, 234683, 117342,
            58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
            7, 4, 2, 1};
        if (i < 30)
            return steps[i];
        return 0;
    endfunction

    task automatic sine_cosine(input longint ang, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit flip;
        x = UNIT_GAIN;
        y = 0;
        flip = 0;
        if (ang > HALF)
            ang -= TURN;
        else if (ang < -HALF)
            ang += TURN;
        z = ang * SCALE;
        if (z > Q90)
        begin
            z -= Q180;
            flip = 1;
        end
        else if (z < -Q90)
        begin
            z += Q180;
            flip = 1;
        end
        for (int i = 0; i < STAGES && i < MAX_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_heading(input logic signed [MAG_W-1:0] fx,
                                   input logic signed [MAG_W-1:0] fy,
                                   input logic signed [MAG_W-1:0] fz,
                                   input logic signed [IN_ANG_W-1:0] pa,
                                   input logic signed [IN_ANG_W-1:0] ra,
                                   output logic [HEAD_W-1:0] hd);
        longint sp, cp, sr, cr, xh, yh, x, y, z, dx, dy, h;
        longint lx, ly, lz;
        lx = fx;
        ly = fy;
        lz = fz;
        sine_cosine(longint'(pa), sp, cp);
        sine_cosine(longint'(ra), sr, cr);
        xh = lx * cp + lz * sp;
        yh = lx * ((sr * sp) >>> 30) + ly * cr - lz * ((sr * cp) >>> 30);
        if (xh == 0 && yh == 0)
        begin
            hd = '0;
            return;
        end
        if (xh < 0)
        begin
            x = -xh; y = -yh; z = Q180;
        end
        else
        begin
            x = xh; y = yh; z = 0;
        end
        for (int i = 0; i < STAGES && i < MAX_STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
            else
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        if (z < 0)
            z += Q360;
        h = (z + SCALE / 2) >>> 16;
        if (h >= TURN)
            h -= TURN;
        if (h < 0)
            h = 0;
        hd = h[HEAD_W-1:0];
    endtask

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(1, 3);
        return 0;
    endfunction

    task automatic send_word(input logic [MAG_W-1:0] fx, input logic [MAG_W-1:0] fy,
                             input logic [MAG_W-1:0] fz, input logic [IN_ANG_W-1:0] pa,
                             input logic [IN_ANG_W-1:0] ra, input bit gaps);
        logic [HEAD_W-1:0] hd;
        int gap;
        gap = gaps ? gap_length() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predict_heading(fx, fy, fz, pa, ra, hd);
        heading_queue.push_back(hd);
        in_valid <= 1'b1;
        field_x <= fx;
        field_y <= fy;
        field_z <= fz;
        pitch_angle <= pa;
        roll_angle <= ra;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_in++;
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [IN_ANG_W-1:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return IN_ANG_W'($urandom);
            1: return IN_ANG_W'($signed($urandom_range(0, 2 * 11520)) - 11520);
            default: return IN_ANG_W'($signed($urandom_range(0, 2 * 23040)) - 23040);
        endcase
    endfunction

    task automatic test_directed();
        logic [MAG_W-1:0] mag_ends[4] = '{13'h1000, 13'h0fff, 13'h0000, 13'h1fff};
        logic [IN_ANG_W-1:0] ang_ends[7] = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd11520,
            16'sh7fff, 16'sh8000, 16'sd11521};
        send_word(0, 0, 0, 0, 0, 0);
        send_word(0, 0, 0, 16'sd4000, -16'sd7000, 0);
        send_word(-13'sd100, 0, 0, 0, 0, 0);
        send_word(-13'sd100, -13'sd1, 0, 0, 0, 0);
        send_word(13'sd1000, -13'sd1, 0, 0, 0, 0);
        send_word(-13'sd1000, 13'sd1, 0, 0, 0, 0);
        send_word(13'sd1, 0, 0, 0, 0, 0);
        for (int i = 0; i < 7; i++)
            send_word(mag_ends[i % 4], mag_ends[(i + 1) % 4], mag_ends[(i + 2) % 4],
                      ang_ends[i], ang_ends[6 - i], 0);
        for (int i = 0; i < 4; i++)
            send_word(mag_ends[i], mag_ends[3 - i], mag_ends[i], ang_ends[i + 3],
                      ang_ends[i], 1);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_word(MAG_W'($urandom), MAG_W'($urandom), MAG_W'($urandom),
                      rand_angle(), rand_angle(), 1);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1;
                repeat (3 * LATENCY) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 2 * LATENCY; i++)
                send_word(MAG_W'($urandom), MAG_W'($urandom), MAG_W'($urandom),
                          rand_angle(), rand_angle(), 0);
        join
    endtask

    task automatic test_streaming();
        stall_enable = 0;
        for (int i = 0; i < 100; i++)
            send_word(MAG_W'($urandom), MAG_W'($urandom), MAG_W'($urandom),
                      rand_angle(), rand_angle(), 0);
        stall_enable = 1;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_off)
            out_ready <= 1'b0;
        else if (!stall_enable)
            out_ready <= 1'b1;
        else if ($urandom_range(0, 39) == 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 3) != 0) || !out_ready;
    end

    always @(posedge clk)
    begin
        logic [HEAD_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            words_out++;
            if (heading_queue.size() == 0)
            begin
                $error("unexpected heading_angle word: %0d", heading_angle);
                fail_count++;
            end
            else
            begin
                want = heading_queue.pop_front();
                if (heading_angle !== want)
                begin
                    $error("heading_angle expected %0d actual %0d", want, heading_angle);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        field_x = '0;
        field_y = '0;
        field_z = '0;
        pitch_angle = '0;
        roll_angle = '0;
        fail_count = 0;
        words_in = 0;
        words_out = 0;
        idle_cycles = 0;
        hold_off = 0;
        stall_enable = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        idle_input();
        test_backpressure();
        idle_input();
        test_streaming();
        idle_input();
        test_random(500);
        idle_input();
        while (heading_queue.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (heading_queue.size() != 0)
            fail_count++;
        $display("sent %0d words, checked %0d headings: field and angle extremes,", words_in,
                 words_out);
        $display("wrapped angles, zero vector, full-rate streaming and output stall");
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
